[rtl/ddo_pkg.sv]
`default_nettype none

package ddo_pkg;

  // width of the theta numerator, also the number of divider steps
  localparam int unsigned NumW = 57;
  // theta divisor and remainder width (twice the wheel base)
  localparam int unsigned DthW = 21;
  // radius divisor and remainder width (twice the wheel difference)
  localparam int unsigned DrW = 33;
  // angle residue modulo two pi, q24
  localparam int unsigned ModW = 27;
  // cordic angle accumulator
  localparam int unsigned ZW = 28;
  // position offset from the centre of curvature
  localparam int unsigned OffW = 35;
  // position vector inside the cordic, 6 guard bits
  localparam int unsigned PosW = 42;
  // heading vector inside the cordic, 16 guard bits
  localparam int unsigned HdW = 35;
  localparam int unsigned AtanEntries = 24;

  localparam logic [ModW-1:0] TwoPiQ24 = 27'd105414357;
  localparam logic signed [ZW-1:0] TwoPiZ = 28'sd105414357;
  localparam logic signed [ZW-1:0] PiZ = 28'sd52707179;
  localparam logic signed [ZW-1:0] HalfPiZ = 28'sd26353589;

  // converged cordic gain, q30
  localparam logic [29:0] GainQ30 = 30'd652032874;

  // atan(2^-i) in q24
  localparam logic [23:0] AtanQ24 [AtanEntries] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
    24'd1047214, 24'd524117, 24'd262123, 24'd131069,
    24'd65536, 24'd32768, 24'd16384, 24'd8192,
    24'd4096, 24'd2048, 24'd1024, 24'd512,
    24'd256, 24'd128, 24'd64, 24'd32,
    24'd16, 24'd8, 24'd4, 24'd2
  };

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] hx;
    logic signed [15:0] hy;
    logic signed [31:0] dr;
    logic               straight;
  } pose_t;

  typedef struct packed {
    pose_t           pose;
    logic            th_neg;
    logic            r_neg;
    logic [NumW-1:0] nth;
    logic [DthW-1:0] dth;
    logic [DthW-1:0] rth;
    logic [ModW-1:0] m;
    logic [NumW-1:0] nr;
    logic [DrW-1:0]  drr;
    logic [DrW-1:0]  rr;
    logic [31:0]     qr;
    logic            ovf;
  } div_stage_t;

  typedef struct packed {
    pose_t                  pose;
    logic signed [OffW-1:0] ox;
    logic signed [OffW-1:0] oy;
    logic signed [PosW-1:0] qx;
    logic signed [PosW-1:0] qy;
    logic signed [HdW-1:0]  gx;
    logic signed [HdW-1:0]  gy;
    logic signed [ZW-1:0]   z;
  } cordic_t;

endpackage

`default_nettype wire

[rtl/ddo_div_stage.sv]
`default_nettype none

module ddo_div_stage import ddo_pkg::*; #(
  parameter int unsigned BIT_IDX = 0
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       valid_i,
  input  div_stage_t      data_i,
  output logic            valid_o,
  output div_stage_t      data_o
);

  div_stage_t data_d;
  div_stage_t data_q;
  logic       valid_q;

  always_comb begin
    logic [DthW:0] th_try;
    logic          th_bit;
    logic [ModW:0] m_try;
    logic [DrW:0]  r_try;
    logic          r_bit;
    data_d = data_i;
    // one restoring step of the angle quotient
    th_try = {data_i.rth, data_i.nth[BIT_IDX]};
    th_bit = (th_try >= {1'b0, data_i.dth});
    data_d.rth = th_bit ? DthW'(th_try - {1'b0, data_i.dth}) : th_try[DthW-1:0];
    // quotient bits fold straight into the residue modulo two pi
    m_try = {data_i.m, th_bit};
    data_d.m = (m_try >= {1'b0, TwoPiQ24}) ? ModW'(m_try - {1'b0, TwoPiQ24})
                                           : m_try[ModW-1:0];
    // one restoring step of the radius quotient, overflow is sticky
    r_try = {data_i.rr, data_i.nr[BIT_IDX]};
    r_bit = (r_try >= {1'b0, data_i.drr});
    data_d.rr = r_bit ? DrW'(r_try - {1'b0, data_i.drr}) : r_try[DrW-1:0];
    data_d.qr = {data_i.qr[30:0], r_bit};
    data_d.ovf = data_i.ovf | data_i.qr[31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[rtl/ddo_cordic_stage.sv]
`default_nettype none

module ddo_cordic_stage import ddo_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  cordic_t   data_i,
  output logic      valid_o,
  output cordic_t   data_o
);

  cordic_t data_d;
  cordic_t data_q;
  logic    valid_q;

  always_comb begin
    logic signed [PosW-1:0] qx, qy, sqx, sqy;
    logic signed [HdW-1:0]  gx, gy, sgx, sgy;
    logic signed [ZW-1:0]   z, step;
    qx = data_i.qx;
    qy = data_i.qy;
    gx = data_i.gx;
    gy = data_i.gy;
    z = data_i.z;
    sqx = qx >>> STAGE;
    sqy = qy >>> STAGE;
    sgx = gx >>> STAGE;
    sgy = gy >>> STAGE;
    step = $signed({{(ZW-24){1'b0}}, AtanQ24[STAGE]});
    data_d = data_i;
    // z not negative turns anticlockwise
    if (!z[ZW-1]) begin
      data_d.qx = qx - sqy;
      data_d.qy = qy + sqx;
      data_d.gx = gx - sgy;
      data_d.gy = gy + sgx;
      data_d.z = z - step;
    end else begin
      data_d.qx = qx + sqy;
      data_d.qy = qy - sqx;
      data_d.gx = gx + sgy;
      data_d.gy = gy - sgx;
      data_d.z = z + step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[rtl/diff_drive_odometry_update.sv]
`default_nettype none

// differential drive odometry update: each item carries a pose (q16.16 position, q1.14
// heading vector) and the two wheel travels; the result is the new pose, either moved
// straight along the heading or rotated about the centre of curvature by a cordic.
// fully pipelined: one item per cycle while the output is not stalled, through the 57
// one-bit steps of the angle and radius long division, the cordic stages and eleven
// set-up and rounding stages. a stalled output freezes the whole pipeline in place.
// wheel_base is written on the cfg channel, which is always ready; a zero wheel base
// is taken as one.

module diff_drive_odometry_update import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [19:0]        wheel_base_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] pose_x_i,
  input  wire logic signed [31:0] pose_y_i,
  input  wire logic signed [15:0] head_x_i,
  input  wire logic signed [15:0] head_y_i,
  input  wire logic signed [31:0] left_travel_i,
  input  wire logic signed [31:0] right_travel_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      new_x_o,
  output logic signed [31:0]      new_y_o,
  output logic signed [15:0]      new_head_x_o,
  output logic signed [15:0]      new_head_y_o
);

  localparam int unsigned NumRot =
    (CORDIC_STAGES > AtanEntries) ? AtanEntries : CORDIC_STAGES;

  // stage records
  typedef struct packed {
    pose_t       pose;
    logic        th_neg;
    logic        r_neg;
    logic [31:0] diff_mag;
    logic [32:0] sum_mag;
    logic [19:0] w;
  } a_t;

  typedef struct packed {
    pose_t       pose;
    logic        th_neg;
    logic        r_neg;
    logic [31:0] diff_mag;
    logic [19:0] w;
    logic [52:0] prod;
  } b_t;

  typedef struct packed {
    pose_t              pose;
    logic [ModW-1:0]    m;
    logic signed [31:0] rad;
  } r1_t;

  typedef struct packed {
    pose_t                pose;
    logic signed [ZW-1:0] z;
    logic                 flip;
    logic signed [48:0]   pa;
    logic signed [48:0]   pb;
    logic signed [46:0]   gpx;
    logic signed [46:0]   gpy;
  } r2_t;

  typedef struct packed {
    pose_t                  pose;
    logic signed [ZW-1:0]   z;
    logic                   flip;
    logic signed [OffW-1:0] ox;
    logic signed [OffW-1:0] oy;
    logic signed [32:0]     gx;
    logic signed [32:0]     gy;
  } r3_t;

  typedef struct packed {
    pose_t                  pose;
    logic signed [ZW-1:0]   z;
    logic                   flip;
    logic signed [OffW-1:0] ox;
    logic signed [OffW-1:0] oy;
    logic signed [48:0]     phx;
    logic signed [48:0]     phy;
    logic [46:0]            plx;
    logic [46:0]            ply;
    logic signed [32:0]     gx;
    logic signed [32:0]     gy;
  } r4_t;

  typedef struct packed {
    pose_t                  pose;
    logic signed [ZW-1:0]   z;
    logic                   flip;
    logic signed [OffW-1:0] ox;
    logic signed [OffW-1:0] oy;
    logic signed [35:0]     qx;
    logic signed [35:0]     qy;
    logic signed [32:0]     gx;
    logic signed [32:0]     gy;
  } r5_t;

  typedef struct packed {
    pose_t              pose;
    logic signed [36:0] dx;
    logic signed [36:0] dy;
    logic signed [18:0] rhx;
    logic signed [18:0] rhy;
  } f1_t;

  // global advance: every stage moves when the output register can take an item
  logic adv;
  logic out_valid_q;

  assign adv = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // configuration register
  logic [19:0] wheel_base_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_base_q <= 20'd13107;
    end else if (cfg_valid_i) begin
      wheel_base_q <= wheel_base_i;
    end
  end

  // stage a: wheel difference and sum, magnitudes and signs
  a_t a_d, a_q;
  logic a_v_q;

  always_comb begin
    logic [32:0] diff, sum;
    diff = {right_travel_i[31], right_travel_i} - {left_travel_i[31], left_travel_i};
    sum  = {right_travel_i[31], right_travel_i} + {left_travel_i[31], left_travel_i};
    a_d.pose.px = pose_x_i;
    a_d.pose.py = pose_y_i;
    a_d.pose.hx = head_x_i;
    a_d.pose.hy = head_y_i;
    a_d.pose.dr = right_travel_i;
    a_d.pose.straight = (left_travel_i == right_travel_i);
    a_d.th_neg = diff[32];
    a_d.r_neg = sum[32] ^ diff[32];
    a_d.diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
    a_d.sum_mag = sum[32] ? (-sum) : sum;
    a_d.w = (wheel_base_q == '0) ? 20'd1 : wheel_base_q;
  end

  // stage b: radius numerator product
  b_t b_d, b_q;
  logic b_v_q;

  always_comb begin
    b_d.pose = a_q.pose;
    b_d.th_neg = a_q.th_neg;
    b_d.r_neg = a_q.r_neg;
    b_d.diff_mag = a_q.diff_mag;
    b_d.w = a_q.w;
    b_d.prod = a_q.w * a_q.sum_mag;
  end

  // stage c: divider operands, with the half-divisor rounding term folded in
  div_stage_t c_d;

  always_comb begin
    c_d.pose = b_q.pose;
    c_d.th_neg = b_q.th_neg;
    c_d.r_neg = b_q.r_neg;
    c_d.nth = {b_q.diff_mag, 5'b0, b_q.w};
    c_d.dth = {b_q.w, 1'b0};
    c_d.rth = '0;
    c_d.m = '0;
    c_d.nr = NumW'({b_q.prod, 1'b0}) + NumW'(b_q.diff_mag);
    c_d.drr = {b_q.diff_mag, 1'b0};
    c_d.rr = '0;
    c_d.qr = '0;
    c_d.ovf = 1'b0;
  end

  // long division, one quotient bit per stage for both angle and radius
  logic       div_v [NumW+1];
  div_stage_t div_d [NumW+1];

  for (genvar k = 0; k < NumW; k++) begin : g_div
    ddo_div_stage #(
      .BIT_IDX(NumW - 1 - k)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(div_v[k]),
      .data_i (div_d[k]),
      .valid_o(div_v[k+1]),
      .data_o (div_d[k+1])
    );
  end

  // r1: signed angle residue and saturated radius
  r1_t r1_d, r1_q;
  logic r1_v_q;

  always_comb begin
    logic [32:0] mag;
    div_stage_t dv;
    dv = div_d[NumW];
    mag = {dv.ovf, dv.qr};
    r1_d.pose = dv.pose;
    // a negative angle maps to two pi minus its residue
    r1_d.m = (dv.th_neg && (dv.m != '0)) ? ModW'(TwoPiQ24 - dv.m) : dv.m;
    if (dv.r_neg) begin
      r1_d.rad = (mag >= 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(-mag);
    end else begin
      r1_d.rad = (mag >= 33'h0_8000_0000) ? 32'sh7fff_ffff : mag[31:0];
    end
  end

  // r2: angle into the half-turn range, offset and gain products
  r2_t r2_d, r2_q;
  logic r2_v_q;

  always_comb begin
    logic signed [ZW-1:0] tm, t;
    logic signed [16:0]   ma1, ma2;
    logic signed [31:0]   mb;
    logic signed [30:0]   gain_s;
    tm = $signed({1'b0, r1_q.m});
    t = (tm > PiZ) ? (tm - TwoPiZ) : tm;
    r2_d.pose = r1_q.pose;
    if (t > HalfPiZ) begin
      r2_d.z = t - PiZ;
      r2_d.flip = 1'b1;
    end else if (t < -HalfPiZ) begin
      r2_d.z = t + PiZ;
      r2_d.flip = 1'b1;
    end else begin
      r2_d.z = t;
      r2_d.flip = 1'b0;
    end
    // straight move shares the multipliers: heading times travel
    if (r1_q.pose.straight) begin
      ma1 = {r1_q.pose.hx[15], r1_q.pose.hx};
      ma2 = {r1_q.pose.hy[15], r1_q.pose.hy};
      mb = r1_q.pose.dr;
    end else begin
      ma1 = {r1_q.pose.hy[15], r1_q.pose.hy};
      ma2 = -$signed({r1_q.pose.hx[15], r1_q.pose.hx});
      mb = r1_q.rad;
    end
    gain_s = $signed({1'b0, GainQ30});
    r2_d.pa = ma1 * mb;
    r2_d.pb = ma2 * mb;
    r2_d.gpx = r1_q.pose.hx * gain_s;
    r2_d.gpy = r1_q.pose.hy * gain_s;
  end

  // r3: round offsets to q16.16 and scaled headings to the guard format
  r3_t r3_d, r3_q;
  logic r3_v_q;

  always_comb begin
    logic signed [48:0] ta, tb;
    logic signed [46:0] tgx, tgy;
    ta = r2_q.pa + 49'sd8192;
    tb = r2_q.pb + 49'sd8192;
    tgx = r2_q.gpx + 47'sd8192;
    tgy = r2_q.gpy + 47'sd8192;
    r3_d.pose = r2_q.pose;
    r3_d.z = r2_q.z;
    r3_d.flip = r2_q.flip;
    r3_d.ox = ta[48:14];
    r3_d.oy = tb[48:14];
    r3_d.gx = tgx[46:14];
    r3_d.gy = tgy[46:14];
  end

  // r4: offset times gain as two partial products
  r4_t r4_d, r4_q;
  logic r4_v_q;

  always_comb begin
    logic signed [17:0] hix, hiy;
    logic signed [30:0] gain_s;
    gain_s = $signed({1'b0, GainQ30});
    hix = r3_q.ox[34:17];
    hiy = r3_q.oy[34:17];
    r4_d.pose = r3_q.pose;
    r4_d.z = r3_q.z;
    r4_d.flip = r3_q.flip;
    r4_d.ox = r3_q.ox;
    r4_d.oy = r3_q.oy;
    r4_d.phx = hix * gain_s;
    r4_d.phy = hiy * gain_s;
    r4_d.plx = r3_q.ox[16:0] * GainQ30;
    r4_d.ply = r3_q.oy[16:0] * GainQ30;
    r4_d.gx = r3_q.gx;
    r4_d.gy = r3_q.gy;
  end

  // r5: combine partial products and round back from q30
  r5_t r5_d, r5_q;
  logic r5_v_q;

  always_comb begin
    logic signed [66:0] sx, sy;
    sx = ($signed({{18{r4_q.phx[48]}}, r4_q.phx}) <<< 17) + $signed({20'b0, r4_q.plx})
         + 67'sd536870912;
    sy = ($signed({{18{r4_q.phy[48]}}, r4_q.phy}) <<< 17) + $signed({20'b0, r4_q.ply})
         + 67'sd536870912;
    r5_d.pose = r4_q.pose;
    r5_d.z = r4_q.z;
    r5_d.flip = r4_q.flip;
    r5_d.ox = r4_q.ox;
    r5_d.oy = r4_q.oy;
    r5_d.qx = sx[65:30];
    r5_d.qy = sy[65:30];
    r5_d.gx = r4_q.gx;
    r5_d.gy = r4_q.gy;
  end

  // r6: guard bits and the half-turn flip of both vectors
  cordic_t r6_d;

  always_comb begin
    logic signed [PosW-1:0] qx, qy;
    logic signed [HdW-1:0]  gx, gy;
    qx = {r5_q.qx, 6'b0};
    qy = {r5_q.qy, 6'b0};
    gx = {{2{r5_q.gx[32]}}, r5_q.gx};
    gy = {{2{r5_q.gy[32]}}, r5_q.gy};
    r6_d.pose = r5_q.pose;
    r6_d.ox = r5_q.ox;
    r6_d.oy = r5_q.oy;
    r6_d.z = r5_q.z;
    r6_d.qx = r5_q.flip ? -qx : qx;
    r6_d.qy = r5_q.flip ? -qy : qy;
    r6_d.gx = r5_q.flip ? -gx : gx;
    r6_d.gy = r5_q.flip ? -gy : gy;
  end

  // cordic rotation, position and heading steered by the same angle
  logic    cor_v [NumRot+1];
  cordic_t cor_d [NumRot+1];

  for (genvar i = 0; i < NumRot; i++) begin : g_cordic
    ddo_cordic_stage #(
      .STAGE(i)
    ) u_cordic (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(cor_v[i]),
      .data_i (cor_d[i]),
      .valid_o(cor_v[i+1]),
      .data_o (cor_d[i+1])
    );
  end

  // f1: drop guard bits, position delta against the centre offset
  f1_t f1_d, f1_q;
  logic f1_v_q;

  always_comb begin
    logic signed [PosW-1:0] tqx, tqy;
    logic signed [HdW-1:0]  tgx, tgy;
    logic signed [36:0]     oxe, oye, rqx, rqy;
    cordic_t cv;
    cv = cor_d[NumRot];
    tqx = cv.qx + 42'sd32;
    tqy = cv.qy + 42'sd32;
    tgx = cv.gx + 35'sd32768;
    tgy = cv.gy + 35'sd32768;
    oxe = {{2{cv.ox[34]}}, cv.ox};
    oye = {{2{cv.oy[34]}}, cv.oy};
    rqx = {tqx[41], tqx[41:6]};
    rqy = {tqy[41], tqy[41:6]};
    f1_d.pose = cv.pose;
    f1_d.dx = cv.pose.straight ? oxe : (rqx - oxe);
    f1_d.dy = cv.pose.straight ? oye : (rqy - oye);
    f1_d.rhx = tgx[34:16];
    f1_d.rhy = tgy[34:16];
  end

  // output stage: add to the old position and saturate
  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if ((v[37:31] == '0) || (v[37:31] == '1)) begin
      return v[31:0];
    end
    return v[37] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if ((v[18:15] == '0) || (v[18:15] == '1)) begin
      return v[15:0];
    end
    return v[18] ? 16'sh8000 : 16'sh7fff;
  endfunction

  logic signed [31:0] new_x_d, new_y_d, new_x_q, new_y_q;
  logic signed [15:0] new_hx_d, new_hy_d, new_hx_q, new_hy_q;

  always_comb begin
    logic signed [37:0] sx, sy;
    sx = {{6{f1_q.pose.px[31]}}, f1_q.pose.px} + {f1_q.dx[36], f1_q.dx};
    sy = {{6{f1_q.pose.py[31]}}, f1_q.pose.py} + {f1_q.dy[36], f1_q.dy};
    new_x_d = sat32(sx);
    new_y_d = sat32(sy);
    new_hx_d = f1_q.pose.straight ? f1_q.pose.hx : sat16(f1_q.rhx);
    new_hy_d = f1_q.pose.straight ? f1_q.pose.hy : sat16(f1_q.rhy);
  end

  // stage registers around the divider and cordic chains
  logic       c_v_q;
  div_stage_t c_q;
  logic       r6_v_q;
  cordic_t    r6_q;

  assign div_v[0] = c_v_q;
  assign div_d[0] = c_q;
  assign cor_v[0] = r6_v_q;
  assign cor_d[0] = r6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
      r3_v_q <= 1'b0;
      r4_v_q <= 1'b0;
      r5_v_q <= 1'b0;
      r6_v_q <= 1'b0;
      f1_v_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      r1_v_q <= div_v[NumW];
      r2_v_q <= r1_v_q;
      r3_v_q <= r2_v_q;
      r4_v_q <= r3_v_q;
      r5_v_q <= r4_v_q;
      r6_v_q <= r5_v_q;
      f1_v_q <= cor_v[NumRot];
      out_valid_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
      r1_q <= r1_d;
      r2_q <= r2_d;
      r3_q <= r3_d;
      r4_q <= r4_d;
      r5_q <= r5_d;
      r6_q <= r6_d;
      f1_q <= f1_d;
      new_x_q <= new_x_d;
      new_y_q <= new_y_d;
      new_hx_q <= new_hx_d;
      new_hy_q <= new_hy_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_x_o = new_x_q;
  assign new_y_o = new_y_q;
  assign new_head_x_o = new_hx_q;
  assign new_head_y_o = new_hy_q;

endmodule

`default_nettype wire
